// ===== hw/rtl/bsed_pkg.sv =====
// Shared types, character codes and the hex digit helper function of the backslash escape decoder.
package bsed_pkg;

    localparam int unsigned RES_MAX = 3;
    localparam int unsigned RES_CNT_W = 2;
    localparam int unsigned VALUE_W = 9;

    typedef enum logic [2:0] {
        PH_NORMAL  = 3'd0,
        PH_AFTER   = 3'd1,
        PH_OCT     = 3'd2,
        PH_HEX     = 3'd3,
        PH_DISCARD = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_UNKNOWN  = 2'd1,
        ST_TRAILING = 2'd2
    } t_status;

    localparam logic REG_INTERPRET = 1'b0;
    localparam logic REG_GNU       = 1'b1;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_A      = 8'h61;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_C      = 8'h63;
    localparam logic [7:0] CH_E      = 8'h65;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_V      = 8'h76;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_SEVEN  = 8'h37;

    localparam logic [7:0] CODE_BEL = 8'h07;
    localparam logic [7:0] CODE_BS  = 8'h08;
    localparam logic [7:0] CODE_TAB = 8'h09;
    localparam logic [7:0] CODE_LF  = 8'h0A;
    localparam logic [7:0] CODE_VT  = 8'h0B;
    localparam logic [7:0] CODE_FF  = 8'h0C;
    localparam logic [7:0] CODE_CR  = 8'h0D;
    localparam logic [7:0] CODE_ESC = 8'h1B;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       string_end;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       end_of_string;
        logic [1:0] status;
        logic       last_of_run;
    } t_out_item;

    typedef struct packed {
        t_out_item [RES_MAX-1:0] items;
        logic [RES_CNT_W-1:0]    count;
    } t_res_set;

    // Returns {valid, digit value} for an ASCII hex digit.
    function automatic logic [4:0] hex_val(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, 4'(b - 8'h30)};
        end else if (b >= 8'h61 && b <= 8'h66) begin
            r = {1'b1, 4'(b - 8'h57)};
        end else if (b >= 8'h41 && b <= 8'h46) begin
            r = {1'b1, 4'(b - 8'h37)};
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/bsed_decode.sv =====
// Escape parser state and the single-pass decode of one byte into up to three results.
module bsed_decode (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_commit,
    input  bsed_pkg::t_in_item i_item,
    input  logic             i_interpret,
    input  logic             i_gnu,
    output bsed_pkg::t_res_set o_set
);
    import bsed_pkg::*;

    t_phase               r_phase, n_phase;
    logic [VALUE_W-1:0]   r_value, n_value;
    logic [1:0]           r_dcnt, n_dcnt;
    logic [1:0]           r_status, n_status;

    logic [7:0]           bytes [RES_MAX];
    logic [RES_MAX-1:0]   has;
    logic [RES_CNT_W-1:0] cnt;
    logic                 do_normal;
    logic [1:0]           st;
    logic [4:0]           hv;
    logic [7:0]           b;
    logic                 last;
    logic                 is_end;

    always_comb begin
        b = i_item.in_byte;
        is_end = i_item.string_end;
        hv = hex_val(b);
        n_phase = r_phase;
        n_value = r_value;
        n_dcnt = r_dcnt;
        n_status = r_status;
        cnt = '0;
        has = '0;
        do_normal = 1'b0;
        for (int k = 0; k < RES_MAX; k++) begin
            bytes[k] = 8'd0;
        end

        if (!i_interpret) begin
            bytes[cnt] = b; has[cnt] = 1'b1; cnt = cnt + 1'b1;
        end else begin
            unique case (r_phase)
                PH_AFTER: begin
                    n_phase = PH_NORMAL;
                    unique case (b)
                        CH_A: begin
                            bytes[cnt] = CODE_BEL; has[cnt] = 1'b1; cnt = cnt + 1'b1;
                        end
                        CH_B: begin
                            bytes[cnt] = CODE_BS; has[cnt] = 1'b1; cnt = cnt + 1'b1;
                        end
                        CH_F: begin
                            bytes[cnt] = CODE_FF; has[cnt] = 1'b1; cnt = cnt + 1'b1;
                        end
                        CH_N: begin
                            bytes[cnt] = CODE_LF; has[cnt] = 1'b1; cnt = cnt + 1'b1;
                        end
                        CH_R: begin
                            bytes[cnt] = CODE_CR; has[cnt] = 1'b1; cnt = cnt + 1'b1;
                        end
                        CH_T: begin
                            bytes[cnt] = CODE_TAB; has[cnt] = 1'b1; cnt = cnt + 1'b1;
                        end
                        CH_V: begin
                            bytes[cnt] = CODE_VT; has[cnt] = 1'b1; cnt = cnt + 1'b1;
                        end
                        CH_BSLASH: begin
                            bytes[cnt] = CH_BSLASH; has[cnt] = 1'b1; cnt = cnt + 1'b1;
                        end
                        CH_C: begin
                            n_phase = PH_DISCARD;
                        end
                        CH_ZERO: begin
                            n_value = '0;
                            n_dcnt = 2'd0;
                            if (is_end) begin
                                bytes[cnt] = 8'd0; has[cnt] = 1'b1; cnt = cnt + 1'b1;
                            end else begin
                                n_phase = PH_OCT;
                            end
                        end
                        default: begin
                            if (i_gnu && b == CH_E) begin
                                bytes[cnt] = CODE_ESC; has[cnt] = 1'b1; cnt = cnt + 1'b1;
                            end else if (i_gnu && b == CH_X) begin
                                n_value = '0;
                                n_dcnt = 2'd0;
                                if (is_end) begin
                                    bytes[cnt] = CH_BSLASH; has[cnt] = 1'b1; cnt = cnt + 1'b1;
                                    bytes[cnt] = CH_X; has[cnt] = 1'b1; cnt = cnt + 1'b1;
                                end else begin
                                    n_phase = PH_HEX;
                                end
                            end else begin
                                bytes[cnt] = CH_BSLASH; has[cnt] = 1'b1; cnt = cnt + 1'b1;
                                bytes[cnt] = b; has[cnt] = 1'b1; cnt = cnt + 1'b1;
                                n_status = ST_UNKNOWN;
                            end
                        end
                    endcase
                end
                PH_OCT: begin
                    if (b >= CH_ZERO && b <= CH_SEVEN) begin
                        n_value = {r_value[VALUE_W-4:0], b[2:0]};
                        n_dcnt = r_dcnt + 2'd1;
                        if (n_dcnt == 2'd3 || is_end) begin
                            bytes[cnt] = n_value[7:0]; has[cnt] = 1'b1; cnt = cnt + 1'b1;
                            n_phase = PH_NORMAL;
                        end
                    end else begin
                        bytes[cnt] = r_value[7:0]; has[cnt] = 1'b1; cnt = cnt + 1'b1;
                        n_phase = PH_NORMAL;
                        do_normal = 1'b1;
                    end
                end
                PH_HEX: begin
                    if (hv[4]) begin
                        n_value = {r_value[VALUE_W-5:0], hv[3:0]};
                        n_dcnt = r_dcnt + 2'd1;
                        if (n_dcnt >= 2'd2 || is_end) begin
                            bytes[cnt] = n_value[7:0]; has[cnt] = 1'b1; cnt = cnt + 1'b1;
                            n_phase = PH_NORMAL;
                        end
                    end else begin
                        if (r_dcnt == 2'd0) begin
                            bytes[cnt] = CH_BSLASH; has[cnt] = 1'b1; cnt = cnt + 1'b1;
                            bytes[cnt] = CH_X; has[cnt] = 1'b1; cnt = cnt + 1'b1;
                        end else begin
                            bytes[cnt] = r_value[7:0]; has[cnt] = 1'b1; cnt = cnt + 1'b1;
                        end
                        n_phase = PH_NORMAL;
                        do_normal = 1'b1;
                    end
                end
                PH_DISCARD: begin
                end
                default: begin
                    do_normal = 1'b1;
                end
            endcase

            if (do_normal) begin
                if (b == CH_BSLASH) begin
                    if (is_end) begin
                        bytes[cnt] = CH_BSLASH; has[cnt] = 1'b1; cnt = cnt + 1'b1;
                        n_status = ST_TRAILING;
                    end else begin
                        n_phase = PH_AFTER;
                    end
                end else begin
                    bytes[cnt] = b; has[cnt] = 1'b1; cnt = cnt + 1'b1;
                end
            end
        end

        if (is_end && cnt == '0) begin
            bytes[cnt] = 8'd0; has[cnt] = 1'b0; cnt = cnt + 1'b1;
        end

        st = i_interpret ? n_status : ST_OK;

        for (int k = 0; k < RES_MAX; k++) begin
            last = (RES_CNT_W'(k) + 1'b1) == cnt;
            o_set.items[k].out_byte = bytes[k];
            o_set.items[k].has_byte = has[k];
            o_set.items[k].status = st;
            o_set.items[k].last_of_run = last;
            o_set.items[k].end_of_string = last && is_end;
        end
        o_set.count = cnt;

        if (is_end) begin
            n_phase = PH_NORMAL;
            n_value = '0;
            n_dcnt = 2'd0;
            n_status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_NORMAL;
            r_value <= '0;
            r_dcnt <= 2'd0;
            r_status <= ST_OK;
        end else if (i_commit) begin
            r_phase <= n_phase;
            r_value <= n_value;
            r_dcnt <= n_dcnt;
            r_status <= n_status;
        end
    end

`ifndef SYNTHESIS
    a_end_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_commit && i_item.string_end) |-> (o_set.count != '0))
        else $error("string end produced no result");
    a_end_clears_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_commit && i_item.string_end) |=> (r_phase == PH_NORMAL && r_status == ST_OK))
        else $error("parser state not cleared at string end");
`endif

endmodule

// ===== hw/rtl/bsed_result_buf.sv =====
// Result register that holds up to three decoded results and hands them out in order.
module bsed_result_buf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  bsed_pkg::t_res_set  i_set,
    output logic                o_ready,
    output logic                o_valid,
    output bsed_pkg::t_out_item o_item,
    input  logic                i_stall
);
    import bsed_pkg::*;

    t_out_item            r_item [RES_MAX];
    logic [RES_CNT_W-1:0] r_cnt;
    logic                 taken;

    assign o_valid = r_cnt != '0;
    assign o_item  = r_item[0];
    assign taken   = o_valid && !i_stall;
    assign o_ready = (r_cnt == '0) || (r_cnt == RES_CNT_W'(1) && !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_set.count;
        end else if (taken) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int k = 0; k < RES_MAX; k++) begin
                r_item[k] <= i_set.items[k];
            end
        end else if (taken) begin
            for (int k = 0; k < RES_MAX - 1; k++) begin
                r_item[k] <= r_item[k+1];
            end
        end
    end

`ifndef SYNTHESIS
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (r_cnt == '0 || (r_cnt == RES_CNT_W'(1) && !i_stall)))
        else $error("result register overwritten while still holding results");
    a_final_marks_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == RES_CNT_W'(1)) |-> r_item[0].last_of_run)
        else $error("final held result does not close its run");
`endif

endmodule

// ===== hw/rtl/backslash_escape_decoder_unit.sv =====
// Top level of the backslash escape decoder: input register, configuration and result path.
//
// Usage: string bytes enter on the input channel (i_in_valid, o_in_stall, i_in_item), one
// per transaction, with string_end set on the last byte of each string. Decoded results
// leave on the output channel (o_out_valid, i_out_stall, o_out_item). A transaction on
// either channel completes at a rising edge where valid is high and stall is low.
// An accepted byte is held in the input register, is decoded there and written into the
// result register at the first edge where that register is ready, and its first result is
// offered from then on. A byte that yields one result or none keeps the result register
// ready while the output is not stalled, so a byte can be accepted every cycle while the
// output is not stalled; a byte that yields two or three results occupies the result
// register for that many output transactions, and the input stalls meanwhile. Stalling the
// output holds the offered result and, once the input register is full, back-pressures the
// input. Reset empties both registers, returns the parser to normal text and sets both
// configuration bits to one. Configuration writes through i_cfg_we, i_cfg_index and
// i_cfg_wdata take effect at the next edge and are to be made only while the block is idle.
module backslash_escape_decoder_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  bsed_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output bsed_pkg::t_out_item o_out_item,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic                i_cfg_wdata
);
    import bsed_pkg::*;

    logic     r_interpret;
    logic     r_gnu;
    logic     r_in_valid;
    t_in_item r_in;
    logic     buf_ready;
    logic     commit;
    logic     in_accept;
    t_res_set res_set;

    assign commit     = r_in_valid && buf_ready;
    assign o_in_stall = r_in_valid && !buf_ready;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interpret <= 1'b1;
            r_gnu <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_INTERPRET: r_interpret <= i_cfg_wdata;
                REG_GNU:       r_gnu <= i_cfg_wdata;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (commit) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_in_item;
        end
    end

    bsed_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_commit    (commit),
        .i_item      (r_in),
        .i_interpret (r_interpret),
        .i_gnu       (r_gnu),
        .o_set       (res_set)
    );

    bsed_result_buf u_result_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (commit),
        .i_set   (res_set),
        .o_ready (buf_ready),
        .o_valid (o_out_valid),
        .o_item  (o_out_item),
        .i_stall (i_out_stall)
    );

`ifndef SYNTHESIS
    a_held_item_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !commit) |=> (r_in_valid && $stable(r_in)))
        else $error("input register lost a byte that was not decoded");
`endif

endmodule
